>>> sv/gpg_pkg.sv
// Shared types and constants for the glottal pulse generator.
// Used by gpg_div, gpg_mul and glottal_pulse_generator_core; depends on nothing.
`default_nettype none
package gpg_pkg;

  localparam int FRAC_BITS = 16;

  localparam int PHASE_W  = 16;
  localparam int TIME_W   = 17;
  localparam int OFFSET_W = 18;
  localparam int SAMPLE_W = 19;
  localparam int PULSE_W  = 19;
  localparam int V_W      = 20;

  localparam int QUOT_W   = 16;
  localparam int MUL_A_W  = 20;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0]   ONE_Q      = TIME_W'(1) << FRAC_BITS;
  localparam logic [15:0]         LFSR_TAPS  = 16'hB400;
  localparam logic [15:0]         LFSR_SEED  = 16'hACE1;
  localparam logic [TIME_W-1:0]   OPEN_RST   = 17'd26214;
  localparam logic [TIME_W-1:0]   CLOSE_RST  = 17'd45875;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 18'd0;
  localparam logic [TIME_W-1:0]   NOISE_RST  = 17'd0;

  localparam logic signed [21:0] SAMPLE_MAX = 22'sd262143;
  localparam logic signed [21:0] SAMPLE_MIN = -22'sd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_TIME  = 2'd0,
    REG_CLOSE_TIME = 2'd1,
    REG_DC_OFFSET  = 2'd2,
    REG_NOISE_MIX  = 2'd3
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SQ   = 6'b000100,
    ST_CUBE = 6'b001000,
    ST_MIX  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic                start;
    logic [QUOT_W-1:0]   num;
    logic [TIME_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic [MUL_B_W-1:0]         b;
  } mul_req_t;

endpackage
`default_nettype wire

>>> sv/gpg_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, numerator scaled by 2^16.
// Depends on gpg_pkg. The numerator must be below the denominator.
`default_nettype none
module gpg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gpg_pkg::div_req_t           req,
  output logic                             done,
  output logic [gpg_pkg::QUOT_W-1:0]       quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [gpg_pkg::TIME_W-1:0]    rem_r, rem_nxt;
  logic [gpg_pkg::TIME_W-1:0]    den_r, den_nxt;
  logic [gpg_pkg::QUOT_W-1:0]    q_r, q_nxt;
  logic [gpg_pkg::TIME_W:0]      shifted;
  logic [gpg_pkg::TIME_W:0]      diff;
  logic                          fits;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    fits     = shifted >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      q_nxt    = '0;
    end else if (busy_r) begin
      // The remainder stays below the denominator, so it fits back in 17 bits.
      rem_nxt = fits ? diff[gpg_pkg::TIME_W-1:0] : shifted[gpg_pkg::TIME_W-1:0];
      q_nxt   = {q_r[gpg_pkg::QUOT_W-2:0], fits};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

>>> sv/gpg_mul.sv
// Bit-serial shift-add multiplier: signed 20-bit by unsigned 17-bit, one bit per cycle.
// Depends on gpg_pkg. The product holds after done until the next start.
`default_nettype none
module gpg_mul (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gpg_pkg::mul_req_t                 req,
  output logic                                   done,
  output logic signed [gpg_pkg::PROD_W-1:0]      prod
);

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [4:0]                            cnt_r, cnt_nxt;
  logic signed [gpg_pkg::MUL_A_W-1:0]    a_r, a_nxt;
  logic signed [gpg_pkg::MUL_A_W:0]      hi_r, hi_nxt;
  logic [gpg_pkg::MUL_B_W-1:0]           lo_r, lo_nxt;
  logic signed [gpg_pkg::MUL_A_W:0]      sum;

  always_comb begin
    // The partial product stays below the multiplicand in magnitude, so the
    // sum cannot overflow the guard bit.
    sum      = lo_r[0] ? (hi_r + {a_r[gpg_pkg::MUL_A_W-1], a_r}) : hi_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(gpg_pkg::MUL_B_W - 1);
      a_nxt    = req.a;
      hi_nxt   = '0;
      lo_nxt   = req.b;
    end else if (busy_r) begin
      hi_nxt  = {sum[gpg_pkg::MUL_A_W], sum[gpg_pkg::MUL_A_W:1]};
      lo_nxt  = {sum[0], lo_r[gpg_pkg::MUL_B_W-1:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r[gpg_pkg::MUL_A_W-1:0], lo_r};

endmodule
`default_nettype wire

>>> sv/glottal_pulse_generator_core.sv
// Top level of the Rosenberg glottal pulse generator: sequencer, registers and LFSR.
// Depends on gpg_pkg, gpg_div and gpg_mul.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_phase   [15:0] unsigned Q0.16
//   out      output     out_valid / out_stall out_sample [18:0] signed Q3.16
//   cfg      input      cfg_valid / cfg_ready cfg_index [1:0], cfg_wdata [17:0]
//
// One item at a time. A phase in the rising part goes through the divide and three serial
// multiplies (square, cube, mix) before the result is handed over; one in the falling part
// through the divide, the square and the mix, and one in the closed part through the mix only.
// The noise product runs on a second multiplier alongside. The output register lets a new
// item in while a result waits on out_stall; a second result waiting adds its stall cycles.
// Reset is synchronous; configuration writes are always taken.
`default_nettype none
module glottal_pulse_generator_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [gpg_pkg::PHASE_W-1:0]          in_phase,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [gpg_pkg::SAMPLE_W-1:0]       out_sample,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gpg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gpg_pkg::OFFSET_W-1:0]         cfg_wdata
);

  gpg_pkg::state_t                     state_r, state_nxt;
  logic [gpg_pkg::TIME_W-1:0]          open_time_r, open_time_nxt;
  logic [gpg_pkg::TIME_W-1:0]          close_time_r, close_time_nxt;
  logic [gpg_pkg::OFFSET_W-1:0]        dc_offset_r, dc_offset_nxt;
  logic [gpg_pkg::TIME_W-1:0]          noise_mix_r, noise_mix_nxt;
  logic [15:0]                         lfsr_r, lfsr_nxt;
  logic                                rise_r, rise_nxt;
  logic [gpg_pkg::QUOT_W-1:0]          x_r, x_nxt;
  logic [gpg_pkg::QUOT_W-1:0]          sq_r, sq_nxt;
  logic signed [gpg_pkg::SAMPLE_W-1:0] res_r, res_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [gpg_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic [gpg_pkg::TIME_W-1:0]          t1c, t2c, nc, one_minus_n;
  logic [15:0]                         lfsr_step;
  logic                                take, in_rise, in_fall;
  logic [gpg_pkg::QUOT_W-1:0]          prod_hi;
  logic signed [gpg_pkg::PULSE_W-1:0]  pulse_rise, pulse_fall;
  logic signed [gpg_pkg::V_W-1:0]      a0_ext, v_rise, v_fall;
  logic signed [21:0]                  mix_sum;

  gpg_pkg::div_req_t                   div_req;
  gpg_pkg::mul_req_t                   mul_req, noise_req;
  logic                                div_done, mul_done, noise_done;
  logic [gpg_pkg::QUOT_W-1:0]          div_quot;
  logic signed [gpg_pkg::PROD_W-1:0]   mul_prod, noise_prod;

  gpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  gpg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gpg_mul u_noise_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (noise_req),
    .done  (noise_done),
    .prod  (noise_prod)
  );

  // Configuration registers.
  always_comb begin
    open_time_nxt  = open_time_r;
    close_time_nxt = close_time_r;
    dc_offset_nxt  = dc_offset_r;
    noise_mix_nxt  = noise_mix_r;
    if (cfg_valid) begin
      unique case (gpg_pkg::cfg_reg_t'(cfg_index))
        gpg_pkg::REG_OPEN_TIME:  open_time_nxt  = cfg_wdata[gpg_pkg::TIME_W-1:0];
        gpg_pkg::REG_CLOSE_TIME: close_time_nxt = cfg_wdata[gpg_pkg::TIME_W-1:0];
        gpg_pkg::REG_DC_OFFSET:  dc_offset_nxt  = cfg_wdata;
        gpg_pkg::REG_NOISE_MIX:  noise_mix_nxt  = cfg_wdata[gpg_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t1c         = (open_time_r  > gpg_pkg::ONE_Q) ? gpg_pkg::ONE_Q : open_time_r;
    t2c         = (close_time_r > gpg_pkg::ONE_Q) ? gpg_pkg::ONE_Q : close_time_r;
    nc          = (noise_mix_r  > gpg_pkg::ONE_Q) ? gpg_pkg::ONE_Q : noise_mix_r;
    one_minus_n = gpg_pkg::ONE_Q - nc;
    lfsr_step   = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? gpg_pkg::LFSR_TAPS : 16'h0000);
    take        = in_valid && (state_r == gpg_pkg::ST_IDLE);
    in_rise     = {1'b0, in_phase} < t1c;
    in_fall     = !in_rise && ({1'b0, in_phase} < t2c);
    a0_ext      = {{(gpg_pkg::V_W - gpg_pkg::OFFSET_W){dc_offset_r[gpg_pkg::OFFSET_W-1]}},
                   dc_offset_r};

    // Take the product over 2^16 for the squares and the cube.
    prod_hi    = mul_prod[2*gpg_pkg::FRAC_BITS-1:gpg_pkg::FRAC_BITS];
    pulse_fall = $signed({2'b00, gpg_pkg::ONE_Q}) - $signed({3'b000, prod_hi});
    pulse_rise = $signed({3'b000, sq_r} + {2'b00, sq_r, 1'b0})
                 - $signed({2'b00, prod_hi, 1'b0});
    v_fall     = {pulse_fall[gpg_pkg::PULSE_W-1], pulse_fall} + a0_ext;
    v_rise     = {pulse_rise[gpg_pkg::PULSE_W-1], pulse_rise} + a0_ext;

    // An arithmetic shift of the signed product floors it.
    mix_sum = 22'(mul_prod >>> gpg_pkg::FRAC_BITS)
              + $signed({6'b000000, noise_prod[2*gpg_pkg::FRAC_BITS-1:gpg_pkg::FRAC_BITS]});
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    lfsr_nxt       = lfsr_r;
    rise_nxt       = rise_r;
    x_nxt          = x_r;
    sq_nxt         = sq_r;
    res_nxt        = res_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && out_stall;

    div_req.start  = 1'b0;
    div_req.num    = in_rise ? in_phase : (in_phase - t1c[gpg_pkg::PHASE_W-1:0]);
    div_req.den    = in_rise ? t1c : (t2c - t1c);

    mul_req.start  = 1'b0;
    mul_req.a      = a0_ext;
    mul_req.b      = one_minus_n;

    noise_req.start = take;
    noise_req.a     = {4'b0000, lfsr_step};
    noise_req.b     = nc;

    unique case (state_r)
      gpg_pkg::ST_IDLE: begin
        if (take) begin
          lfsr_nxt = lfsr_step;
          rise_nxt = in_rise;
          if (in_rise || in_fall) begin
            div_req.start = 1'b1;
            state_nxt     = gpg_pkg::ST_DIV;
          end else begin
            // Closed part: the pulse is zero, so only the offset is mixed.
            mul_req.start = 1'b1;
            state_nxt     = gpg_pkg::ST_MIX;
          end
        end
      end
      gpg_pkg::ST_DIV: begin
        if (div_done) begin
          x_nxt         = div_quot;
          mul_req.start = 1'b1;
          mul_req.a     = {4'b0000, div_quot};
          mul_req.b     = {1'b0, div_quot};
          state_nxt     = gpg_pkg::ST_SQ;
        end
      end
      gpg_pkg::ST_SQ: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          if (rise_r) begin
            sq_nxt    = prod_hi;
            mul_req.a = {4'b0000, prod_hi};
            mul_req.b = {1'b0, x_r};
            state_nxt = gpg_pkg::ST_CUBE;
          end else begin
            mul_req.a = v_fall;
            state_nxt = gpg_pkg::ST_MIX;
          end
        end
      end
      gpg_pkg::ST_CUBE: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = v_rise;
          state_nxt     = gpg_pkg::ST_MIX;
        end
      end
      gpg_pkg::ST_MIX: begin
        // The noise multiplier started with the item, so it never finishes after this one.
        if (mul_done) begin
          priority if (mix_sum > gpg_pkg::SAMPLE_MAX) begin
            res_nxt = gpg_pkg::SAMPLE_MAX[gpg_pkg::SAMPLE_W-1:0];
          end else if (mix_sum < gpg_pkg::SAMPLE_MIN) begin
            res_nxt = gpg_pkg::SAMPLE_MIN[gpg_pkg::SAMPLE_W-1:0];
          end else begin
            res_nxt = mix_sum[gpg_pkg::SAMPLE_W-1:0];
          end
          state_nxt = gpg_pkg::ST_DONE;
        end
      end
      gpg_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_sample_nxt = res_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = gpg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gpg_pkg::ST_IDLE;
      open_time_r  <= gpg_pkg::OPEN_RST;
      close_time_r <= gpg_pkg::CLOSE_RST;
      dc_offset_r  <= gpg_pkg::OFFSET_RST;
      noise_mix_r  <= gpg_pkg::NOISE_RST;
      lfsr_r       <= gpg_pkg::LFSR_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      open_time_r  <= open_time_nxt;
      close_time_r <= close_time_nxt;
      dc_offset_r  <= dc_offset_nxt;
      noise_mix_r  <= noise_mix_nxt;
      lfsr_r       <= lfsr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rise_r       <= rise_nxt;
    x_r          <= x_nxt;
    sq_r         <= sq_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign in_stall   = (state_r != gpg_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign cfg_ready  = 1'b1;

endmodule
`default_nettype wire
